[design/sgb_pkg.sv]
package sgb_pkg;

	localparam int GLYPH_COUNT_DEF   = 128;
	localparam int FRAME_ROWS_DEF    = 128;
	localparam int WORDS_PER_ROW_DEF = 16;
	localparam int MAX_SCALE_DEF     = 16;

	localparam int GLYPH_ROWS  = 8;
	localparam int NIBBLE_BITS = 4;
	localparam int NIBBLES     = 8;
	localparam int WORD_W      = 32;
	localparam int IN_W        = 68;
	localparam int QDEPTH      = 2;

	typedef enum logic [1:0] {
		MODE_CLEAR = 2'd0,
		MODE_LOAD  = 2'd1,
		MODE_DRAW  = 2'd2,
		MODE_READ  = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t       mode;
		logic [6:0]  glyph_index;
		logic [2:0]  glyph_row;
		logic [31:0] glyph_word;
		logic [3:0]  tile_row;
		logic [3:0]  tile_col;
		logic [4:0]  scale;
		logic [6:0]  read_row;
		logic [3:0]  read_col;
		logic        glyph_ok;
		logic        read_ok;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_GREAD,
		ST_FREAD,
		ST_FWRITE,
		ST_RWAIT,
		ST_DONE
	} state_t;

	function automatic logic [31:0] merge_word(logic [31:0] old, logic [31:0] src);
		logic [31:0] res;
		res = src;
		for (int n = 0; n < NIBBLES; n++) begin
			if (src[n*4 +: 4] == 4'd0)
				res[n*4 +: 4] = old[n*4 +: 4];
		end
		return res;
	endfunction

endpackage

[design/sgb_ram.sv]
module sgb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

[design/sgb_front.sv]
module sgb_front #(
	parameter int GLYPH_COUNT   = 128,
	parameter int FRAME_ROWS    = 128,
	parameter int WORDS_PER_ROW = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [67:0]           s_tdata,
	output logic                  cmd_valid,
	input  logic                  cmd_ready,
	output sgb_pkg::cmd_t         cmd
);
	import sgb_pkg::*;

	cmd_t       q_q [QDEPTH];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	cmd_t       c;
	logic       push, pop;

	always_comb begin
		c.mode        = mode_t'(s_tdata[1:0]);
		c.glyph_index = s_tdata[8:2];
		c.glyph_row   = s_tdata[11:9];
		c.glyph_word  = s_tdata[43:12];
		c.tile_row    = s_tdata[47:44];
		c.tile_col    = s_tdata[51:48];
		c.scale       = s_tdata[56:52];
		c.read_row    = s_tdata[63:57];
		c.read_col    = s_tdata[67:64];
		c.glyph_ok    = 32'(c.glyph_index) < GLYPH_COUNT;
		c.read_ok     = 32'(c.read_row) < FRAME_ROWS && 32'(c.read_col) < WORDS_PER_ROW;
	end

	assign s_tready  = cnt_q != 2'(QDEPTH);
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd       = q_q[rp_q];
	assign push      = s_tvalid && s_tready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push)
			q_q[wp_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (pop)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

[design/sgb_back.sv]
module sgb_back #(
	parameter int GLYPH_COUNT   = 128,
	parameter int FRAME_ROWS    = 128,
	parameter int WORDS_PER_ROW = 16,
	parameter int MAX_SCALE     = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  sgb_pkg::cmd_t cmd,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [39:0]   m_tdata
);
	import sgb_pkg::*;

	localparam int FDEPTH = FRAME_ROWS * WORDS_PER_ROW;
	localparam int GDEPTH = GLYPH_COUNT * GLYPH_ROWS;
	localparam int FA_W   = $clog2(FDEPTH);
	localparam int GA_W   = $clog2(GDEPTH);
	localparam int RW     = $clog2(FRAME_ROWS) + 1;
	localparam int CW     = $clog2(WORDS_PER_ROW) + 1;
	localparam int SW     = $clog2(MAX_SCALE + 1);
	localparam int PW     = 8;

	state_t            st_q, st_n;
	cmd_t              c_q;
	logic [SW-1:0]     s_q;
	logic [2:0]        i_q;
	logic [SW-1:0]     v_q, k_q;
	logic [RW+8:0]     r_q;
	logic [FA_W:0]     clr_q;
	logic [31:0]       gw_q;
	logic              clip_q;
	logic [31:0]       rd_q;
	logic              ov_q;

	logic              g_we;
	logic [GA_W-1:0]   g_wa, g_ra;
	logic [31:0]       g_rd;
	logic              f_we;
	logic [FA_W-1:0]   f_wa, f_ra;
	logic [31:0]       f_wd, f_rd;

	logic [RW+8:0]     c_abs;
	logic              in_rng;
	logic [FA_W-1:0]   tgt;
	logic [31:0]       line;
	logic [PW-1:0]     p, gi;
	logic              last_k, last_v, last_i;

	sgb_ram #(.WIDTH(32), .DEPTH(GDEPTH)) u_gram (
		.clk(clk), .we(g_we), .waddr(g_wa), .wdata(c_q.glyph_word),
		.raddr(g_ra), .rdata(g_rd)
	);
	sgb_ram #(.WIDTH(32), .DEPTH(FDEPTH)) u_fram (
		.clk(clk), .we(f_we), .waddr(f_wa), .wdata(f_wd),
		.raddr(f_ra), .rdata(f_rd)
	);

	assign c_abs  = (RW+9)'(c_q.tile_col) + (RW+9)'(k_q);
	assign in_rng = r_q < (RW+9)'(FRAME_ROWS) && c_abs < (RW+9)'(WORDS_PER_ROW);
	assign tgt    = FA_W'(r_q * (RW+9)'(WORDS_PER_ROW) + c_abs);
	assign last_k = k_q == s_q - SW'(1);
	assign last_v = v_q == s_q - SW'(1);
	assign last_i = i_q == 3'd7;

	always_comb begin
		line = '0;
		for (int n = 0; n < NIBBLES; n++) begin
			p  = PW'(k_q) * PW'(NIBBLES) + PW'(n);
			gi = '0;
			for (int d = 0; d < NIBBLES; d++) begin
				if (p >= PW'(d) * PW'(s_q) && p < PW'(d + 1) * PW'(s_q))
					gi = PW'(d);
			end
			line[n*4 +: 4] = gw_q[gi[2:0]*4 +: 4];
		end
	end

	always_comb begin
		g_we = 1'b0;
		g_wa = GA_W'(32'(c_q.glyph_index) * GLYPH_ROWS + 32'(c_q.glyph_row));
		g_ra = GA_W'(32'(c_q.glyph_index) * GLYPH_ROWS + 32'(i_q));
		f_we = 1'b0;
		f_wa = tgt;
		f_wd = merge_word(f_rd, line);
		f_ra = tgt;
		unique case (st_q)
			ST_CLEAR: begin
				f_we = 1'b1;
				f_wa = FA_W'(clr_q);
				f_wd = '0;
			end
			ST_FWRITE: f_we = in_rng;
			ST_RWAIT: f_ra = FA_W'(32'(c_q.read_row) * WORDS_PER_ROW + 32'(c_q.read_col));
			ST_DONE: g_we = c_q.mode == MODE_LOAD && c_q.glyph_ok;
			default: ;
		endcase
	end

	always_comb begin
		st_n = st_q;
		unique case (st_q)
			ST_IDLE: if (cmd_valid && !ov_q) begin
				unique case (mode_t'(cmd.mode))
					MODE_CLEAR: st_n = ST_CLEAR;
					MODE_LOAD:  st_n = ST_DONE;
					MODE_DRAW:  st_n = cmd.scale == 5'd0 ? ST_DONE : ST_GREAD;
					MODE_READ:  st_n = ST_RWAIT;
					default:    st_n = ST_DONE;
				endcase
			end
			ST_CLEAR:  if (clr_q == (FA_W+1)'(FDEPTH - 1)) st_n = ST_DONE;
			ST_GREAD:  st_n = ST_FREAD;
			ST_FREAD:  st_n = ST_FWRITE;
			ST_FWRITE: st_n = (last_k && last_v && last_i) ? ST_DONE
				: (last_k && last_v) ? ST_GREAD : ST_FREAD;
			ST_RWAIT:  st_n = ST_DONE;
			ST_DONE:   st_n = ST_IDLE;
			default:   st_n = ST_IDLE;
		endcase
	end

	assign cmd_ready = st_q == ST_IDLE && !ov_q;
	assign m_tvalid  = ov_q;
	assign m_tdata   = {7'd0, clip_q, rd_q};

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && cmd_valid && !ov_q) begin
			c_q <= cmd;
			s_q <= cmd.scale > 5'(MAX_SCALE) ? SW'(MAX_SCALE) : SW'(cmd.scale);
		end
		if (st_q == ST_GREAD && !c_q.glyph_ok)
			gw_q <= '0;
		else if (st_q == ST_FREAD && v_q == '0 && k_q == '0)
			gw_q <= c_q.glyph_ok ? g_rd : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			ov_q   <= 1'b0;
			clip_q <= 1'b0;
			rd_q   <= '0;
			i_q    <= '0;
			v_q    <= '0;
			k_q    <= '0;
			r_q    <= '0;
			clr_q  <= '0;
		end else begin
			st_q <= st_n;
			if (m_tvalid && m_tready)
				ov_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (cmd_valid && !ov_q) begin
					clip_q <= 1'b0;
					rd_q   <= '0;
					i_q    <= '0;
					v_q    <= '0;
					k_q    <= '0;
					clr_q  <= '0;
					r_q    <= (RW+9)'(cmd.tile_row) * (RW+9)'(GLYPH_ROWS);
				end
				ST_CLEAR: clr_q <= clr_q + (FA_W+1)'(1);
				ST_FWRITE: begin
					if (!in_rng)
						clip_q <= 1'b1;
					if (!last_k)
						k_q <= k_q + SW'(1);
					else begin
						k_q <= '0;
						r_q <= r_q + (RW+9)'(1);
						if (!last_v)
							v_q <= v_q + SW'(1);
						else begin
							v_q <= '0;
							i_q <= i_q + 3'd1;
						end
					end
				end
				ST_RWAIT: ;
				ST_DONE: begin
					ov_q <= 1'b1;
					if (c_q.mode == MODE_READ && c_q.read_ok)
						rd_q <= f_rd;
				end
				default: ;
			endcase
		end
	end

endmodule

[design/scaled_glyph_blitter_unit.sv]
// Draw reads each glyph row once, then reads and rewrites each in-range target frame word
// in turn through one frame RAM read-modify-write port; clear writes every frame word in turn.
// One item is carried out at a time; a two-entry queue takes the next meanwhile.
// Reset clears control state only; frame contents are undefined until a clear.
module scaled_glyph_blitter_unit #(
	parameter int GLYPH_COUNT   = sgb_pkg::GLYPH_COUNT_DEF,
	parameter int FRAME_ROWS    = sgb_pkg::FRAME_ROWS_DEF,
	parameter int WORDS_PER_ROW = sgb_pkg::WORDS_PER_ROW_DEF,
	parameter int MAX_SCALE     = sgb_pkg::MAX_SCALE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// mode, glyph_index, glyph_row, glyph_word, tile_row, tile_col, scale, read_row, read_col
	input  logic [71:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// read_data, clipped
	output logic [39:0] m_tdata
);
	import sgb_pkg::*;

	logic cmd_valid, cmd_ready;
	cmd_t cmd;

	sgb_front #(.GLYPH_COUNT(GLYPH_COUNT), .FRAME_ROWS(FRAME_ROWS),
		.WORDS_PER_ROW(WORDS_PER_ROW)) u_front (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.s_tdata(s_tdata[67:0]), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
	);

	sgb_back #(.GLYPH_COUNT(GLYPH_COUNT), .FRAME_ROWS(FRAME_ROWS),
		.WORDS_PER_ROW(WORDS_PER_ROW), .MAX_SCALE(MAX_SCALE)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
		.cmd(cmd), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

endmodule
